// ===== design/pcpg_rs_pkg.sv =====
// shared types and constants of the ramp shaper
`timescale 1ns / 1ps

package pcpg_rs_pkg;

	// register indexes of the write port
	localparam logic [1:0] REG_SLOPE_GAIN      = 2'd0;
	localparam logic [1:0] REG_SHIFT_MODE      = 2'd1;
	localparam logic [1:0] REG_LEVEL_THRESHOLD = 2'd2;
	localparam logic [1:0] REG_SHIFT_THRESHOLD = 2'd3;

	// reset values of the registers
	localparam logic [15:0] SLOPE_GAIN_RST      = 16'd16384;
	localparam logic [15:0] LEVEL_THRESHOLD_RST = 16'd13926;
	localparam logic [15:0] SHIFT_THRESHOLD_RST = 16'd13435;

	// q1.14 levels
	localparam logic [15:0] ONE_Q14    = 16'h4000;
	localparam logic [15:0] NEG_ONE    = 16'hC000;
	localparam logic [15:0] RATIO_MAX  = 16'h8000;
	localparam logic [15:0] HIGH_SCALE = 16'h8000;

	// one overflow step plus sixteen quotient bits
	localparam int DIV_STEPS = 17;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_ADV  = 7'b0000010,
		ST_MUL  = 7'b0000100,
		ST_LOAD = 7'b0001000,
		ST_DIV  = 7'b0010000,
		ST_FIN  = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

endpackage

// ===== design/pcpg_ramp_shaper.sv =====
// ramp shaper: thresholds two oscillator channels and shapes them into ramps
`timescale 1ns / 1ps

// usage
// - input beat on s_tvalid/s_tready/s_tdata carries one sample per channel;
//   s_tready is high only while the sequencer is idle
// - result beat on m_tvalid/m_tready/m_tdata carries both shaped outputs,
//   q1.14 clamped to plus/minus one
// - config writes (cfg_we, cfg_addr, cfg_wdata) are registered; the user
//   must write only while no beat is in flight; the block does not check
// sequence
// - a taken beat updates levels and run counters, then each
//   channel does multiply, load, 17 restoring-divide steps and a finish
//   step on one shared subtract/compare unit
// - m_tvalid rises after both channels are finished; no new input beat
//   is taken before the result moves to the output register, so the
//   serial divider, used twice per item, sets the pace of items
// - the result sits in an output register, so the next input beat is
//   taken while a result still waits on m_tready; a stalled receiver only
//   holds the sequencer when a new result is ready to replace it
// reset
// - arst_n clears levels, counters and latched lengths, loads register
//   defaults and drops m_tvalid
module pcpg_ramp_shaper #(
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// sample_a, sample_b, zero pad
	input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// shaped_a, shaped_b
	output logic [31:0]                           m_tdata,
	input  logic                                  cfg_we,
	input  logic [1:0]                            cfg_addr,
	input  logic [15:0]                           cfg_wdata
);

	localparam int CW = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
	localparam int PW = COUNT_BITS + 16;
	localparam int DW = COUNT_BITS + 17;
	localparam int RW = COUNT_BITS + 18;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	pcpg_rs_pkg::state_t state_q;

	// configuration registers
	logic        [15:0] slope_q;
	logic               shift_mode_q;
	logic signed [15:0] level_th_q;
	logic signed [15:0] shift_th_q;

	// per-channel run tracking
	logic [1:0]            level_q;
	logic [COUNT_BITS-1:0] run_q  [2];
	logic [COUNT_BITS-1:0] hlen_q [2];
	logic [COUNT_BITS-1:0] llen_q [2];

	// sequencer and shared datapath
	logic                          ch_q;
	logic [4:0]                    step_q;
	logic signed [SAMPLE_BITS-1:0] samp_q [2];
	logic [PW-1:0]                 prod_q;
	logic [COUNT_BITS-1:0]         den_q;
	logic                          lvl_sel_q;
	logic                          spec_q;
	logic [15:0]                   spec_val_q;
	logic [RW-1:0]                 rem_q;
	logic [DW-1:0]                 dsh_q;
	logic [16:0]                   quo_q;
	logic [15:0]                   res_q [2];
	logic                          m_tvalid_q;
	logic [31:0]                   m_tdata_q;

	logic                          in_fire;
	logic                          out_free;
	logic signed [15:0]            th1;
	logic [1:0]                    hi;
	logic                          cur_lvl;
	logic [15:0]                   cur_s;
	logic [15:0]                   mul_k;
	logic [COUNT_BITS-1:0]         cur_cnt;
	logic [COUNT_BITS-1:0]         cur_h;
	logic [COUNT_BITS-1:0]         cur_l;
	logic                          ge;
	logic [15:0]                   ratio;
	logic signed [16:0]            y;

	assign s_tready = (state_q == pcpg_rs_pkg::ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// level decisions, sample >= threshold means high
	assign th1   = shift_mode_q ? shift_th_q : level_th_q;
	assign hi[0] = CW'(samp_q[0]) >= CW'(level_th_q);
	assign hi[1] = CW'(samp_q[1]) >= CW'(th1);

	// operands of the channel being shaped
	assign cur_lvl = level_q[ch_q];
	assign cur_cnt = run_q[ch_q];
	assign cur_h   = hlen_q[ch_q];
	assign cur_l   = llen_q[ch_q];
	assign cur_s   = ch_q ? slope_q : pcpg_rs_pkg::ONE_Q14;
	// high ramp uses 2*count<<14, low ramp s*count
	assign mul_k   = cur_lvl ? pcpg_rs_pkg::HIGH_SCALE : cur_s;

	// shared subtract/compare unit
	assign ge = rem_q >= RW'(dsh_q);

	// saturate the quotient at two, then form the ramp
	always_comb begin
		if (quo_q[16] || (quo_q[15:0] > pcpg_rs_pkg::RATIO_MAX)) begin
			ratio = pcpg_rs_pkg::RATIO_MAX;
		end else begin
			ratio = quo_q[15:0];
		end
		if (lvl_sel_q) begin
			y = $signed({1'b0, ratio}) - $signed({1'b0, pcpg_rs_pkg::ONE_Q14});
		end else begin
			y = $signed({1'b0, pcpg_rs_pkg::ONE_Q14}) - $signed({1'b0, ratio});
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slope_q      <= pcpg_rs_pkg::SLOPE_GAIN_RST;
			shift_mode_q <= 1'b0;
			level_th_q   <= pcpg_rs_pkg::LEVEL_THRESHOLD_RST;
			shift_th_q   <= pcpg_rs_pkg::SHIFT_THRESHOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				pcpg_rs_pkg::REG_SLOPE_GAIN:      slope_q      <= cfg_wdata;
				pcpg_rs_pkg::REG_SHIFT_MODE:      shift_mode_q <= cfg_wdata[0];
				pcpg_rs_pkg::REG_LEVEL_THRESHOLD: level_th_q   <= cfg_wdata;
				pcpg_rs_pkg::REG_SHIFT_THRESHOLD: shift_th_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sequencer, run tracking and output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pcpg_rs_pkg::ST_IDLE;
			ch_q       <= 1'b0;
			step_q     <= '0;
			level_q    <= '0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				run_q[i]  <= '0;
				hlen_q[i] <= '0;
				llen_q[i] <= '0;
			end
		end else begin
			// a new result replaces a taken one in the same cycle
			if ((state_q == pcpg_rs_pkg::ST_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				pcpg_rs_pkg::ST_IDLE: begin
					if (in_fire) begin
						state_q <= pcpg_rs_pkg::ST_ADV;
					end
				end
				pcpg_rs_pkg::ST_ADV: begin
					for (int i = 0; i < 2; i++) begin
						if (hi[i] != level_q[i]) begin
							// edge: latch the run that just ended
							if (level_q[i]) begin
								hlen_q[i] <= run_q[i];
							end else begin
								llen_q[i] <= run_q[i];
							end
							run_q[i]   <= COUNT_BITS'(1);
							level_q[i] <= hi[i];
						end else if (run_q[i] != CNT_MAX) begin
							run_q[i] <= run_q[i] + COUNT_BITS'(1);
						end
					end
					ch_q    <= 1'b0;
					state_q <= pcpg_rs_pkg::ST_MUL;
				end
				pcpg_rs_pkg::ST_MUL: begin
					state_q <= pcpg_rs_pkg::ST_LOAD;
				end
				pcpg_rs_pkg::ST_LOAD: begin
					step_q  <= '0;
					state_q <= pcpg_rs_pkg::ST_DIV;
				end
				pcpg_rs_pkg::ST_DIV: begin
					if (step_q == 5'(pcpg_rs_pkg::DIV_STEPS - 1)) begin
						state_q <= pcpg_rs_pkg::ST_FIN;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				pcpg_rs_pkg::ST_FIN: begin
					if (ch_q) begin
						state_q <= pcpg_rs_pkg::ST_DONE;
					end else begin
						ch_q    <= 1'b1;
						state_q <= pcpg_rs_pkg::ST_MUL;
					end
				end
				pcpg_rs_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= pcpg_rs_pkg::ST_IDLE;
					end
				end
				default: state_q <= pcpg_rs_pkg::ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			samp_q[0] <= s_tdata[SAMPLE_BITS-1:0];
			samp_q[1] <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
		end
		if (state_q == pcpg_rs_pkg::ST_MUL) begin
			prod_q    <= PW'(cur_cnt) * PW'(mul_k);
			den_q     <= cur_lvl ? cur_h : cur_l;
			lvl_sel_q <= cur_lvl;
			if (cur_lvl) begin
				spec_q     <= (cur_h == '0);
				spec_val_q <= pcpg_rs_pkg::ONE_Q14;
			end else begin
				spec_q     <= (cur_s == '0) || (cur_l == '0);
				spec_val_q <= (cur_s == '0) ? pcpg_rs_pkg::ONE_Q14 : pcpg_rs_pkg::NEG_ONE;
			end
		end
		if (state_q == pcpg_rs_pkg::ST_LOAD) begin
			// round half up: (2*num + den) / (2*den)
			rem_q <= RW'({prod_q, 1'b0}) + RW'(den_q);
			dsh_q <= DW'(den_q) << 17;
		end
		if (state_q == pcpg_rs_pkg::ST_DIV) begin
			if (ge) begin
				rem_q <= rem_q - RW'(dsh_q);
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[15:0], ge};
		end
		if (state_q == pcpg_rs_pkg::ST_FIN) begin
			res_q[ch_q] <= spec_q ? spec_val_q : y[15:0];
		end
		if ((state_q == pcpg_rs_pkg::ST_DONE) && out_free) begin
			m_tdata_q <= {res_q[1], res_q[0]};
		end
	end

	// an accepted beat starts the level update right away
	a_fire_adv: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == pcpg_rs_pkg::ST_ADV)
		else $error("input beat did not start the sequencer");

	// results stay within plus/minus one
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd16384 &&
			$signed(m_tdata[15:0]) >= -16'sd16384 &&
			$signed(m_tdata[31:16]) <= 16'sd16384 &&
			$signed(m_tdata[31:16]) >= -16'sd16384))
		else $error("shaped output outside clamp range");

	// a high channel has counted at least one step
	a_high_run: assert property (@(posedge clk) disable iff (!arst_n)
		(!level_q[0] || run_q[0] != '0) && (!level_q[1] || run_q[1] != '0))
		else $error("high level with empty run count");

	// the output register is loaded only at the end of an item
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == pcpg_rs_pkg::ST_DONE))
		else $error("result beat raised outside the done step");

	// the divider never runs past its step count
	a_div_steps: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pcpg_rs_pkg::ST_DIV |-> step_q < 5'(pcpg_rs_pkg::DIV_STEPS))
		else $error("divider step counter overran");

endmodule

// ===== dv/pcpg_rs_checker.sv =====
// checker for the ramp shaper: predicts shaped outputs and compares result beats
`timescale 1ns / 1ps

module pcpg_rs_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// sample_a, sample_b
	input  logic [31:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// shaped_a, shaped_b
	input  logic [31:0] m_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [15:0] shaped_b;
		logic [15:0] shaped_a;
	} shaped_pair_t;

	shaped_pair_t shaped_q[$];
	int           errors_seen = 0;

	// per channel level tracking
	logic        lvl[2];
	logic [15:0] run_len[2];
	logic [15:0] high_len[2];
	logic [15:0] low_len[2];

	// register shadow
	logic [15:0]        slope_gain;
	logic               shift_mode;
	logic signed [15:0] level_thr;
	logic signed [15:0] shift_thr;

	assign fail_count = errors_seen;

	task automatic report_error(input string msg);
		$display("%0t ns: %s", $time, msg);
		errors_seen++;
	endtask

	// num/den rounded half up, saturated at two
	function automatic longint ramp_ratio(input longint num, input longint den);
		longint q;
		q = (num * 2 + den) / (den * 2);
		return (q > longint'(pcpg_rs_pkg::RATIO_MAX)) ? longint'(pcpg_rs_pkg::RATIO_MAX) : q;
	endfunction

	function automatic logic [15:0] ramp_level(input logic high, input logic [15:0] cnt,
			input logic [15:0] hlen, input logic [15:0] llen, input logic [15:0] gain);
		longint one;
		longint y;
		one = longint'(pcpg_rs_pkg::ONE_Q14);
		if (high) begin
			if (hlen == 16'd0)
				return pcpg_rs_pkg::ONE_Q14;
			y = ramp_ratio(longint'(cnt) * 2 * one, longint'(hlen)) - one;
		end else begin
			if (gain == 16'd0)
				return pcpg_rs_pkg::ONE_Q14;
			if (llen == 16'd0)
				y = -one;
			else
				y = one - ramp_ratio(longint'(gain) * longint'(cnt), longint'(llen));
		end
		if (y > one)
			y = one;
		if (y < -one)
			y = -one;
		return y[15:0];
	endfunction

	task automatic advance_level(input int ch, input logic to_high);
		if (to_high != lvl[ch]) begin
			if (lvl[ch])
				high_len[ch] = run_len[ch];
			else
				low_len[ch] = run_len[ch];
			run_len[ch] = 16'd1;
			lvl[ch] = to_high;
		end else if (run_len[ch] != 16'hFFFF) begin
			run_len[ch] = run_len[ch] + 16'd1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch_proc
		shaped_pair_t       got_pair;
		shaped_pair_t       want_pair;
		logic signed [15:0] thr_b;
		if (!arst_n) begin
			for (int ch = 0; ch < 2; ch++) begin
				lvl[ch] = 1'b0;
				run_len[ch] = 16'd0;
				high_len[ch] = 16'd0;
				low_len[ch] = 16'd0;
			end
			slope_gain = pcpg_rs_pkg::SLOPE_GAIN_RST;
			shift_mode = 1'b0;
			level_thr = pcpg_rs_pkg::LEVEL_THRESHOLD_RST;
			shift_thr = pcpg_rs_pkg::SHIFT_THRESHOLD_RST;
			shaped_q.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					pcpg_rs_pkg::REG_SLOPE_GAIN:      slope_gain = cfg_wdata;
					pcpg_rs_pkg::REG_SHIFT_MODE:      shift_mode = cfg_wdata[0];
					pcpg_rs_pkg::REG_LEVEL_THRESHOLD: level_thr = cfg_wdata;
					pcpg_rs_pkg::REG_SHIFT_THRESHOLD: shift_thr = cfg_wdata;
					default: ;
				endcase
			end
			// results are older than any beat taken at the same edge
			if (m_tvalid && m_tready) begin
				got_pair = m_tdata;
				if (shaped_q.size() == 0) begin
					report_error($sformatf("result beat %h with nothing expected", m_tdata));
				end else begin
					want_pair = shaped_q.pop_front();
					if (got_pair.shaped_a !== want_pair.shaped_a)
						report_error($sformatf("shaped_a got %0d want %0d",
							$signed(got_pair.shaped_a), $signed(want_pair.shaped_a)));
					if (got_pair.shaped_b !== want_pair.shaped_b)
						report_error($sformatf("shaped_b got %0d want %0d",
							$signed(got_pair.shaped_b), $signed(want_pair.shaped_b)));
				end
			end
			if (s_tvalid && s_tready) begin
				thr_b = shift_mode ? shift_thr : level_thr;
				advance_level(0, $signed(s_tdata[15:0]) >= level_thr);
				advance_level(1, $signed(s_tdata[31:16]) >= thr_b);
				want_pair.shaped_a = ramp_level(lvl[0], run_len[0], high_len[0], low_len[0],
					pcpg_rs_pkg::ONE_Q14);
				want_pair.shaped_b = ramp_level(lvl[1], run_len[1], high_len[1], low_len[1],
					slope_gain);
				shaped_q.push_back(want_pair);
			end
			pending <= shaped_q.size();
		end
	end

endmodule

// ===== dv/pcpg_ramp_shaper_test.sv =====
// top of the ramp shaper testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module pcpg_ramp_shaper_test;

	// generous bound, the slowest correct run stays far below it
	localparam int CYCLE_LIMIT = 2000000;
	localparam int WAVE_ITEMS  = 333;
	localparam int HOLD_CYCLES = 600;
	localparam int DRAIN_CYCLES = 60;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// sample_a, sample_b
	logic [31:0] s_tdata = 32'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// shaped_a, shaped_b
	logic [31:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_addr = pcpg_rs_pkg::REG_SLOPE_GAIN;
	logic [15:0] cfg_wdata = 16'd0;

	int fail_count;
	int pending;
	int cycle_count = 0;

	// idle chance in percent per cycle on each side
	int tx_idle_pct = 11;
	int rx_idle_pct = 54;

	// long receiver hold-off, armed once by the stimulus
	logic hold_armed = 1'b0;
	logic hold_done = 1'b0;
	int   hold_left = 0;

	// register values as written, used to place samples around thresholds
	int level_thr_sh = int'($signed(pcpg_rs_pkg::LEVEL_THRESHOLD_RST));
	int shift_thr_sh = int'($signed(pcpg_rs_pkg::SHIFT_THRESHOLD_RST));
	logic shift_mode_sh = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	pcpg_ramp_shaper u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	pcpg_rs_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off so the block backs up
	// and drops s_tready while the sender keeps offering beats
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_armed && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// one input beat; valid stays up into the next beat when no gap follows
	task automatic send_item(input logic [15:0] smp_a, input logic [15:0] smp_b);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {smp_b, smp_a};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// register write, only once every expected result has come back
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		s_tvalid <= 1'b0;
		// let pending catch up first so it covers a beat taken at the last edge
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		case (idx)
			pcpg_rs_pkg::REG_SHIFT_MODE:      shift_mode_sh = val[0];
			pcpg_rs_pkg::REG_LEVEL_THRESHOLD: level_thr_sh = int'($signed(val));
			pcpg_rs_pkg::REG_SHIFT_THRESHOLD: shift_thr_sh = int'($signed(val));
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// sample on the wanted side of a threshold, often right at the boundary
	function automatic logic [15:0] pick_sample(input int thr, input logic want_high);
		int v;
		if (want_high) begin
			if ($urandom_range(7) == 0)
				v = thr;
			else
				v = thr + int'($urandom_range(32767 - thr));
		end else if (thr == -32768) begin
			// nothing lies below the lowest threshold
			v = int'($urandom_range(65535)) - 32768;
		end else if ($urandom_range(7) == 0) begin
			v = thr - 1;
		end else begin
			v = -32768 + int'($urandom_range(thr + 32767));
		end
		return v[15:0];
	endfunction

	// oscillator-like stream: runs of high and low per channel with random
	// lengths, some very long, with random noise beats mixed in
	task automatic run_wave(input int items);
		int          left_a;
		int          left_b;
		logic        hi_a;
		logic        hi_b;
		logic [15:0] smp_a;
		logic [15:0] smp_b;
		int          thr_b;
		left_a = 0;
		left_b = 0;
		hi_a = 1'($urandom_range(1));
		hi_b = 1'($urandom_range(1));
		for (int i = 0; i < items; i++) begin
			thr_b = shift_mode_sh ? shift_thr_sh : level_thr_sh;
			if (left_a == 0) begin
				hi_a = !hi_a;
				left_a = ($urandom_range(9) == 0) ? $urandom_range(200, 25)
					: $urandom_range(24, 1);
			end
			if (left_b == 0) begin
				hi_b = !hi_b;
				left_b = ($urandom_range(9) == 0) ? $urandom_range(200, 25)
					: $urandom_range(24, 1);
			end
			left_a--;
			left_b--;
			smp_a = pick_sample(level_thr_sh, hi_a);
			smp_b = pick_sample(thr_b, hi_b);
			// broken runs: a stray beat anywhere in the range
			if ($urandom_range(11) == 0)
				smp_a = 16'($urandom_range(65535));
			if ($urandom_range(11) == 0)
				smp_b = 16'($urandom_range(65535));
			send_item(smp_a, smp_b);
		end
	endtask

	initial begin
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at register defaults
		// first beat low: latched low length is still zero, output pinned at minus one
		send_item(16'h8000, 16'h8000);
		// first rising edge: high length still zero gives plus one
		send_item(16'h7FFF, 16'h7FFF);
		// sample equal to the threshold counts as high
		send_item(pcpg_rs_pkg::LEVEL_THRESHOLD_RST, pcpg_rs_pkg::LEVEL_THRESHOLD_RST);
		// one below the threshold: falling edge latches the high run
		send_item(pcpg_rs_pkg::LEVEL_THRESHOLD_RST - 16'd1,
			pcpg_rs_pkg::LEVEL_THRESHOLD_RST - 16'd1);
		send_item(16'h0000, 16'h0000);
		send_item(16'hFFFF, 16'hFFFF);
		// channels apart
		send_item(16'h7FFF, 16'h8000);
		send_item(16'h4000, 16'h0001);
		send_item(16'h4000, 16'h8000);
		send_item(16'h0001, 16'h7FFF);

		// zero slope: channel 1 low phase sits at plus one
		write_reg(pcpg_rs_pkg::REG_SLOPE_GAIN, 16'h0000);
		send_item(16'h7FFF, 16'h8000);
		send_item(16'h7FFF, 16'hC000);
		// steepest slope drives channel 1 into the lower clamp
		write_reg(pcpg_rs_pkg::REG_SLOPE_GAIN, 16'hFFFF);
		send_item(16'h8000, 16'h0000);
		send_item(16'h8000, 16'h0000);
		send_item(16'h8000, 16'h0000);

		// shift mode: a sample between the two thresholds splits the channels
		write_reg(pcpg_rs_pkg::REG_SHIFT_MODE, 16'h0001);
		send_item(16'd13500, 16'd13500);
		send_item(pcpg_rs_pkg::SHIFT_THRESHOLD_RST, pcpg_rs_pkg::SHIFT_THRESHOLD_RST);
		send_item(pcpg_rs_pkg::SHIFT_THRESHOLD_RST - 16'd1,
			pcpg_rs_pkg::SHIFT_THRESHOLD_RST - 16'd1);

		// highest level threshold: only the top code is high on channel 0
		write_reg(pcpg_rs_pkg::REG_LEVEL_THRESHOLD, 16'h7FFF);
		write_reg(pcpg_rs_pkg::REG_SHIFT_THRESHOLD, 16'h8000);
		send_item(16'h7FFF, 16'h8000);
		send_item(16'h7FFE, 16'h8000);
		send_item(16'h7FFF, 16'h7FFF);

		// random part in six settings; idling changes every two of them
		for (int ph = 0; ph < 6; ph++) begin
			tx_idle_pct = (ph < 2) ? 11 : (ph < 4) ? 54 : 0;
			rx_idle_pct = (ph < 2) ? 54 : (ph < 4) ? 11 : 0;
			case (ph)
				0: begin
					write_reg(pcpg_rs_pkg::REG_SLOPE_GAIN, 16'h0000);
					write_reg(pcpg_rs_pkg::REG_SHIFT_MODE, 16'h0001);
					write_reg(pcpg_rs_pkg::REG_LEVEL_THRESHOLD, 16'h0000);
					write_reg(pcpg_rs_pkg::REG_SHIFT_THRESHOLD, 16'hE000);
				end
				1: begin
					write_reg(pcpg_rs_pkg::REG_SLOPE_GAIN, 16'hFFFF);
					write_reg(pcpg_rs_pkg::REG_SHIFT_MODE, 16'h0001);
					write_reg(pcpg_rs_pkg::REG_LEVEL_THRESHOLD, 16'h7FFF);
					write_reg(pcpg_rs_pkg::REG_SHIFT_THRESHOLD, 16'h8000);
				end
				2: begin
					write_reg(pcpg_rs_pkg::REG_SLOPE_GAIN, 16'($urandom_range(65535)));
					write_reg(pcpg_rs_pkg::REG_SHIFT_MODE, 16'h0000);
					write_reg(pcpg_rs_pkg::REG_LEVEL_THRESHOLD, 16'h8000);
					write_reg(pcpg_rs_pkg::REG_SHIFT_THRESHOLD, 16'h7FFF);
				end
				3: begin
					write_reg(pcpg_rs_pkg::REG_SLOPE_GAIN, 16'($urandom_range(65535)));
					write_reg(pcpg_rs_pkg::REG_SHIFT_MODE, 16'($urandom_range(1)));
					write_reg(pcpg_rs_pkg::REG_LEVEL_THRESHOLD, 16'($urandom_range(65535)));
					write_reg(pcpg_rs_pkg::REG_SHIFT_THRESHOLD, 16'($urandom_range(65535)));
				end
				4: begin
					write_reg(pcpg_rs_pkg::REG_SLOPE_GAIN, pcpg_rs_pkg::SLOPE_GAIN_RST);
					write_reg(pcpg_rs_pkg::REG_SHIFT_MODE, 16'h0001);
					write_reg(pcpg_rs_pkg::REG_LEVEL_THRESHOLD, 16'($urandom_range(65535)));
					write_reg(pcpg_rs_pkg::REG_SHIFT_THRESHOLD, 16'($urandom_range(65535)));
					// receiver goes quiet for a long stretch during this wave
					hold_armed <= 1'b1;
				end
				default: begin
					write_reg(pcpg_rs_pkg::REG_SLOPE_GAIN, 16'($urandom_range(65535)));
					write_reg(pcpg_rs_pkg::REG_SHIFT_MODE, 16'($urandom_range(1)));
					write_reg(pcpg_rs_pkg::REG_LEVEL_THRESHOLD,
						pcpg_rs_pkg::LEVEL_THRESHOLD_RST);
					write_reg(pcpg_rs_pkg::REG_SHIFT_THRESHOLD,
						pcpg_rs_pkg::SHIFT_THRESHOLD_RST);
				end
			endcase
			run_wave(WAVE_ITEMS);
		end

		// drain: every expected result back, then an idle stretch before the verdict
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
